// File: rtl/sfx_pkg.sv
// sfx_pkg: shared types and constants of the sound effect mixer
// no dependencies
package sfx_pkg;

  localparam int unsigned NumChannels    = 32;
  localparam int unsigned ChanW          = 5;
  localparam int unsigned SampleMemDepth = 65536;
  localparam int unsigned SampleAddrW    = 16;
  localparam logic [16:0] MixOutRate     = 17'd48000;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_START = 3'd1,
    REQ_PAN   = 3'd2,
    REQ_STOP  = 3'd3,
    REQ_QUERY = 3'd4,
    REQ_MIX   = 3'd5
  } req_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  channel;
    logic [7:0]  volume;
    logic [7:0]  separation;
    logic [15:0] address;
    logic [15:0] length;
    logic [15:0] rate;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               playing;
    logic               accepted;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    req_e        op;
    logic        valid_op;
    logic [4:0]  channel;
    logic [6:0]  lgain;
    logic [6:0]  rgain;
    logic [15:0] address;
    logic [15:0] length;
    logic [15:0] rate;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_READ,
    ST_CALC,
    ST_ACC,
    ST_OUT
  } mix_state_e;

  // x*y/127 for 0 <= x*y <= 127*254, truncating
  // reciprocal estimate is low by at most one, fixed by one compare
  function automatic logic [7:0] div127(input logic [14:0] p);
    logic [31:0] prod;
    logic [15:0] q;
    logic [15:0] r;
    begin
      prod = 32'(p) * 32'd516;
      q = prod[31:16];
      r = {1'b0, p} - 16'(q * 16'd127);
      if (r >= 16'd127) q = q + 16'd1;
      div127 = q[7:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [22:0] x);
    begin
      if (x > 23'sd32767) sat16 = 16'sh7fff;
      else if (x < -23'sd32768) sat16 = 16'sh8000;
      else sat16 = x[15:0];
    end
  endfunction

endpackage

// File: rtl/sfx_if.sv
// sfx_if: valid/ready channels for requests and responses
// depends on sfx_pkg
interface sfx_req_if;
  logic          valid;
  logic          ready;
  sfx_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sfx_rsp_if;
  logic          valid;
  logic          ready;
  sfx_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sfx_front.sv
// sfx_front: accepts requests, clamps volume and pan, works out gains
// and pushes classified commands into a short queue; depends on sfx_pkg
module sfx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfx_pkg::req_t in_req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output sfx_pkg::cmd_t cmd_o
);

  sfx_pkg::cmd_t q_mem [sfx_pkg::QueueDepth];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  sfx_pkg::cmd_t cmd_new;
  logic [6:0]    vol;
  logic [7:0]    sep, lg, rg;
  logic          push, pop;

  always_comb begin
    vol = (in_req_i.volume > 8'd127) ? 7'd127 : in_req_i.volume[6:0];
    sep = (in_req_i.separation > 8'd254) ? 8'd254 : in_req_i.separation;
    lg = sfx_pkg::div127(15'(vol * (8'd254 - sep)));
    rg = sfx_pkg::div127(15'(vol * sep));
    cmd_new.op        = sfx_pkg::req_e'(in_req_i.req_type);
    cmd_new.valid_op  = (in_req_i.req_type <= 3'd5);
    cmd_new.channel   = in_req_i.channel;
    cmd_new.lgain     = (lg > 8'd127) ? 7'd127 : lg[6:0];
    cmd_new.rgain     = (rg > 8'd127) ? 7'd127 : rg[6:0];
    cmd_new.address   = in_req_i.address;
    cmd_new.length    = in_req_i.length;
    cmd_new.rate      = in_req_i.rate;
    cmd_new.data_byte = in_req_i.data_byte;
  end

  assign in_ready_o  = (cnt_q != 2'(sfx_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/sfx_back.sv
// sfx_back: executes commands against channel state and sample memory;
// mixes the channels one at a time through read, calc and accumulate states; depends on sfx_pkg
module sfx_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  sfx_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sfx_pkg::rsp_t out_o
);

  logic [7:0]  mem [sfx_pkg::SampleMemDepth];
  logic [15:0] base_m [sfx_pkg::NumChannels];
  logic [15:0] len_m  [sfx_pkg::NumChannels];
  logic [15:0] rate_m [sfx_pkg::NumChannels];
  logic [15:0] pos_m  [sfx_pkg::NumChannels];
  logic [15:0] ph_m   [sfx_pkg::NumChannels];
  logic [6:0]  lg_m   [sfx_pkg::NumChannels];
  logic [6:0]  rg_m   [sfx_pkg::NumChannels];
  logic [sfx_pkg::NumChannels-1:0] act_q;

  sfx_pkg::mix_state_e state_q, state_d;
  sfx_pkg::cmd_t       cmd_q;
  sfx_pkg::rsp_t       rsp_q;
  logic                rsp_valid_q;
  logic [5:0]          ch_q;
  logic [4:0]          ch;
  logic [7:0]          byte_q;
  logic signed [22:0]  lsum_q, rsum_q;
  logic signed [23:0]  lp_q, rp_q;
  logic                live_q;
  logic [16:0]         ph_sum;
  logic [15:0]         ph_new;
  logic [16:0]         pos_new;
  logic [1:0]          wraps;
  logic signed [15:0]  smp;
  logic signed [22:0]  lterm, rterm;
  logic                ctrl_acc, ctrl_play;

  assign ch = ch_q[4:0];
  assign cmd_ready_o = (state_q == sfx_pkg::ST_IDLE);
  assign out_valid_o = rsp_valid_q;
  assign out_o = rsp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfx_pkg::ST_IDLE: if (cmd_valid_i) state_d = sfx_pkg::ST_CMD;
      sfx_pkg::ST_CMD: begin
        if (!rsp_valid_q) begin
          state_d = (cmd_q.op == sfx_pkg::REQ_MIX && cmd_q.valid_op)
                  ? sfx_pkg::ST_READ : sfx_pkg::ST_IDLE;
        end
      end
      sfx_pkg::ST_READ: state_d = sfx_pkg::ST_CALC;
      sfx_pkg::ST_CALC: state_d = sfx_pkg::ST_ACC;
      sfx_pkg::ST_ACC:
        state_d = (ch_q == 6'(sfx_pkg::NumChannels - 1)) ? sfx_pkg::ST_OUT
                                                          : sfx_pkg::ST_READ;
      sfx_pkg::ST_OUT: if (!rsp_valid_q) state_d = sfx_pkg::ST_IDLE;
      default: state_d = sfx_pkg::ST_IDLE;
    endcase
  end

  // response flags of a control transaction
  always_comb begin
    ctrl_acc  = 1'b0;
    ctrl_play = 1'b0;
    if (cmd_q.valid_op) begin
      case (cmd_q.op)
        sfx_pkg::REQ_WRITE: ctrl_acc = 1'b1;
        sfx_pkg::REQ_START: ctrl_acc = (cmd_q.rate != 16'd0);
        sfx_pkg::REQ_PAN:   ctrl_acc = act_q[cmd_q.channel];
        sfx_pkg::REQ_STOP:  ctrl_acc = 1'b1;
        sfx_pkg::REQ_QUERY: begin
          ctrl_play = act_q[cmd_q.channel];
          ctrl_acc  = 1'b1;
        end
        default: ctrl_acc = 1'b0;
      endcase
    end
  end

  // phase advance: rate < 65536 < 2*48000 so at most two wraps
  always_comb begin
    ph_sum = {1'b0, ph_m[ch]} + {1'b0, rate_m[ch]};
    wraps = 2'd0;
    ph_new = ph_sum[15:0];
    if (ph_sum >= 17'd96000) begin
      wraps = 2'd2;
      ph_new = 16'(ph_sum - 17'd96000);
    end else if (ph_sum >= sfx_pkg::MixOutRate) begin
      wraps = 2'd1;
      ph_new = 16'(ph_sum - sfx_pkg::MixOutRate);
    end
    pos_new = {1'b0, pos_m[ch]} + {15'd0, wraps};
    smp = 16'($signed({1'b0, byte_q}) - 9'sd128) <<< 8;
  end

  // truncating signed divide by 127 from magnitude
  function automatic logic signed [22:0] sdiv127(input logic signed [23:0] p);
    logic [23:0] m;
    logic [40:0] q;
    logic [23:0] qq, r;
    begin
      m = p[23] ? 24'(-p) : p;
      q = {17'd0, m} * 41'd132104;
      qq = 24'(q >> 24);
      r = m - 24'(qq * 24'd127);
      if (r >= 24'd127) qq = qq + 24'd1;
      sdiv127 = p[23] ? -23'(qq) : 23'(qq);
    end
  endfunction

  assign lterm = sdiv127(lp_q);
  assign rterm = sdiv127(rp_q);

  always_ff @(posedge clk_i) begin
    if (state_q == sfx_pkg::ST_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == sfx_pkg::ST_CMD && cmd_q.valid_op
        && cmd_q.op == sfx_pkg::REQ_WRITE && !rsp_valid_q) begin
      mem[cmd_q.address] <= cmd_q.data_byte;
    end
    byte_q <= mem[16'(base_m[ch] + pos_m[ch])];
    if (state_q == sfx_pkg::ST_CMD && !rsp_valid_q && cmd_q.valid_op) begin
      if (cmd_q.op == sfx_pkg::REQ_START && cmd_q.rate != 16'd0) begin
        base_m[cmd_q.channel] <= cmd_q.address;
        len_m[cmd_q.channel]  <= cmd_q.length;
        rate_m[cmd_q.channel] <= cmd_q.rate;
        pos_m[cmd_q.channel]  <= 16'd0;
        ph_m[cmd_q.channel]   <= 16'd0;
      end
      if ((cmd_q.op == sfx_pkg::REQ_START && cmd_q.rate != 16'd0)
          || (cmd_q.op == sfx_pkg::REQ_PAN && act_q[cmd_q.channel])) begin
        lg_m[cmd_q.channel] <= cmd_q.lgain;
        rg_m[cmd_q.channel] <= cmd_q.rgain;
      end
    end
    if (state_q == sfx_pkg::ST_READ) begin
      live_q <= act_q[ch] && (pos_m[ch] < len_m[ch]);
    end
    if (state_q == sfx_pkg::ST_CALC) begin
      lp_q <= 24'(smp * $signed({1'b0, lg_m[ch]}));
      rp_q <= 24'(smp * $signed({1'b0, rg_m[ch]}));
      if (live_q) begin
        ph_m[ch]  <= ph_new;
        pos_m[ch] <= pos_new[16] ? 16'hffff : pos_new[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfx_pkg::ST_IDLE;
      act_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      ch_q        <= '0;
      lsum_q      <= '0;
      rsum_q      <= '0;
    end else begin
      state_q <= state_d;
      if (rsp_valid_q && out_ready_i) rsp_valid_q <= 1'b0;
      if (state_q == sfx_pkg::ST_CMD && !rsp_valid_q) begin
        ch_q   <= '0;
        lsum_q <= '0;
        rsum_q <= '0;
        if (!(cmd_q.op == sfx_pkg::REQ_MIX && cmd_q.valid_op)) begin
          rsp_valid_q <= 1'b1;
          rsp_q <= {16'sd0, 16'sd0, ctrl_play, ctrl_acc};
          if (cmd_q.valid_op && cmd_q.op == sfx_pkg::REQ_START) begin
            act_q[cmd_q.channel] <= (cmd_q.rate != 16'd0);
          end else if (cmd_q.valid_op && cmd_q.op == sfx_pkg::REQ_STOP) begin
            act_q[cmd_q.channel] <= 1'b0;
          end
        end
      end
      if (state_q == sfx_pkg::ST_CALC && act_q[ch]) begin
        if (!live_q || pos_new >= {1'b0, len_m[ch]}) act_q[ch] <= 1'b0;
      end
      if (state_q == sfx_pkg::ST_ACC) begin
        if (live_q) begin
          lsum_q <= lsum_q + lterm;
          rsum_q <= rsum_q + rterm;
        end
        ch_q <= ch_q + 6'd1;
      end
      if (state_q == sfx_pkg::ST_OUT && !rsp_valid_q) begin
        rsp_valid_q <= 1'b1;
        rsp_q <= {sfx_pkg::sat16(lsum_q), sfx_pkg::sat16(rsum_q), 1'b0, 1'b1};
      end
    end
  end

endmodule

// File: rtl/sound_effect_mixer.sv
// sound_effect_mixer: 32-channel 8-bit pcm mixer to a stereo 16-bit frame
// a command passes the front queue, then the back end's IDLE and CMD states;
// a mix frame goes on through READ, CALC and ACC for each channel in turn,
// then OUT; the back end takes a new command only in IDLE, after the last
// is done; the front queue holds two; reset clears all channels to inactive,
// sample memory undefined
module sound_effect_mixer (
  input logic clk_i,
  input logic rst_ni,
  sfx_req_if.sink   req,
  sfx_rsp_if.source rsp
);

  logic          cmd_valid, cmd_ready;
  sfx_pkg::cmd_t cmd;

  sfx_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready), .in_req_i (req.payload),
    .cmd_valid_o (cmd_valid), .cmd_ready_i (cmd_ready), .cmd_o (cmd)
  );

  sfx_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid), .cmd_ready_o (cmd_ready), .cmd_i (cmd),
    .out_valid_o (rsp.valid), .out_ready_i (rsp.ready), .out_o (rsp.payload)
  );

  a_rsp_zero_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.payload.accepted |-> rsp.payload.left_sample == 16'sd0)
    else $error("rejected transaction carries mix data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
    else $error("response changed while stalled");

  a_play_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.playing |-> rsp.payload.accepted)
    else $error("playing without accepted");

endmodule

// File: tb/sfx_mix_checker.sv
// sfx_mix_checker: watches the request and response channels of the mixer,
// predicts every response and compares it field by field; depends on sfx_pkg, sfx_if
`timescale 1ns / 100ps
module sfx_mix_checker
  import sfx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sfx_req_if   req_mon,
  sfx_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  logic [7:0]  sample_mem [SampleMemDepth];
  logic [15:0] base_q [NumChannels];
  logic [15:0] len_q [NumChannels];
  logic [15:0] rate_q [NumChannels];
  logic [15:0] pos_q [NumChannels];
  logic [15:0] phase_q [NumChannels];
  int          lgain_q [NumChannels];
  int          rgain_q [NumChannels];
  logic        active_q [NumChannels];

  rsp_t expected_rsps [$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_rsps.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic void set_pan(input int ch, input int vol, input int sep);
    int v;
    int s;
    int l;
    int r;
    v = (vol > 127) ? 127 : vol;
    s = (sep > 254) ? 254 : sep;
    l = v * (254 - s) / 127;
    r = v * s / 127;
    lgain_q[ch] = (l > 127) ? 127 : l;
    rgain_q[ch] = (r > 127) ? 127 : r;
  endfunction

  function automatic logic signed [15:0] clip16(input int x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic rsp_t mix_tick();
    rsp_t r;
    int   lsum;
    int   rsum;
    int   smp;
    int   pos;
    int   ph;
    r    = '0;
    lsum = 0;
    rsum = 0;
    for (int c = 0; c < NumChannels; c++) begin
      if (!active_q[c]) continue;
      pos = pos_q[c];
      if (pos >= len_q[c]) begin
        active_q[c] = 1'b0;
        continue;
      end
      smp = (int'(sample_mem[16'(base_q[c] + pos)]) - 128) * 256;
      lsum += smp * lgain_q[c] / 127;
      rsum += smp * rgain_q[c] / 127;
      ph = phase_q[c] + rate_q[c];
      while (ph >= 48000) begin
        ph -= 48000;
        pos++;
      end
      phase_q[c] = ph[15:0];
      pos_q[c] = (pos > 65535) ? 16'hffff : pos[15:0];
      if (pos >= len_q[c]) active_q[c] = 1'b0;
    end
    r.left_sample  = clip16(lsum);
    r.right_sample = clip16(rsum);
    r.accepted     = 1'b1;
    return r;
  endfunction

  function automatic rsp_t predict_rsp(input req_t q);
    rsp_t r;
    int   ch;
    r  = '0;
    ch = q.channel;
    case (q.req_type)
      REQ_WRITE: begin
        sample_mem[q.address] = q.data_byte;
        r.accepted = 1'b1;
      end
      REQ_START: begin
        active_q[ch] = 1'b0;
        if (q.rate != 0) begin
          base_q[ch]   = q.address;
          len_q[ch]    = q.length;
          rate_q[ch]   = q.rate;
          pos_q[ch]    = '0;
          phase_q[ch]  = '0;
          set_pan(ch, q.volume, q.separation);
          active_q[ch] = 1'b1;
          r.accepted   = 1'b1;
        end
      end
      REQ_PAN: begin
        if (active_q[ch]) begin
          set_pan(ch, q.volume, q.separation);
          r.accepted = 1'b1;
        end
      end
      REQ_STOP: begin
        active_q[ch] = 1'b0;
        r.accepted   = 1'b1;
      end
      REQ_QUERY: begin
        r.playing  = active_q[ch];
        r.accepted = 1'b1;
      end
      REQ_MIX: r = mix_tick();
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    fails = 0;
    for (int c = 0; c < NumChannels; c++) begin
      base_q[c] = '0; len_q[c] = '0; rate_q[c] = '0; pos_q[c] = '0; phase_q[c] = '0;
      lgain_q[c] = 0; rgain_q[c] = 0; active_q[c] = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready) expected_rsps.push_back(predict_rsp(req_mon.payload));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected response transaction", $realtime);
          fails++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.left_sample !== want.left_sample)
            report("left_sample", got.left_sample, want.left_sample);
          if (got.right_sample !== want.right_sample)
            report("right_sample", got.right_sample, want.right_sample);
          if (got.playing !== want.playing) report("playing", got.playing, want.playing);
          if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// tb_top: clock, reset and stimulus for the sound effect mixer; verdict from
// sfx_mix_checker; depends on sfx_pkg, sfx_if, sound_effect_mixer
`timescale 1ns / 100ps
module tb_top;
  import sfx_pkg::*;

  // sounds only play from this loaded window, which wraps past the top address
  localparam logic [15:0] WinStart = 16'hfff0;
  localparam int          WinSize  = 64;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   no_gaps;

  sfx_req_if req ();
  sfx_rsp_if rsp ();

  sound_effect_mixer DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source));

  sfx_mix_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req), .rsp_mon(rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  function automatic req_t mk(input logic [2:0] op, input int ch, input int vol,
                              input int sep, input int addr, input int len,
                              input int rate, input int data);
    req_t q;
    q.req_type = op; q.channel = 5'(ch); q.volume = 8'(vol); q.separation = 8'(sep);
    q.address = 16'(addr); q.length = 16'(len); q.rate = 16'(rate);
    q.data_byte = 8'(data);
    return q;
  endfunction

  // well-formed start of a sound that stays inside the loaded window
  function automatic req_t play_req(input int ch);
    int b;
    b = $urandom_range(0, WinSize - 1);
    return mk(REQ_START, ch, $urandom_range(0, 255), $urandom_range(0, 255),
              WinStart + b, $urandom_range(1, WinSize - b),
              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 65535), 0);
  endfunction

  function automatic req_t random_req();
    int   k;
    req_t q;
    q = mk(REQ_WRITE, $urandom_range(0, 31), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
           $urandom_range(0, 255));
    k = $urandom_range(0, 99);
    if (k < 8) q.req_type = REQ_WRITE;
    else if (k < 15) begin
      q.req_type = REQ_WRITE;
      q.address  = 16'(WinStart + $urandom_range(0, WinSize - 1));
    end else if (k < 35) q = play_req(q.channel);
    else if (k < 38) begin
      q.req_type = REQ_START;  // rejected start, anything else goes
      q.rate     = 16'd0;
    end else if (k < 40) begin
      q.req_type = REQ_START;  // empty sound, base never read
      q.length   = 16'd0;
      if (q.rate == 16'd0) q.rate = 16'd1;
    end else if (k < 50) q.req_type = REQ_PAN;
    else if (k < 57) q.req_type = REQ_STOP;
    else if (k < 66) q.req_type = REQ_QUERY;
    else if (k < 96) q.req_type = REQ_MIX;
    else q.req_type = 3'($urandom_range(6, 7));
    return q;
  endfunction

  task automatic send(input req_t q);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.payload <= q;
    do @(posedge clk_i); while (!req.ready);
  endtask

  initial begin
    int stall;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    no_gaps     = 1'b0;
    req.valid   <= 1'b0;
    req.payload <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the playback window
    for (int i = 0; i < WinSize; i++)
      send(mk(REQ_WRITE, 0, 0, 0, WinStart + i, 0, 0, $urandom_range(0, 255)));

    // directed: field extremes, every request and the corner cases
    send(mk(REQ_WRITE, 0, 0, 0, 16'h0000, 0, 0, 8'h00));
    send(mk(REQ_WRITE, 0, 0, 0, 16'hffff, 0, 0, 8'hff));
    send(mk(REQ_START, 0, 255, 0, 16'hffff, 2, 48000, 0));  // wraps to address 0
    send(mk(REQ_START, 31, 127, 255, WinStart, WinSize, 65535, 0));
    send(mk(REQ_START, 5, 10, 128, 16'h1234, 0, 1000, 0));  // empty sound
    send(mk(REQ_START, 6, 255, 255, 16'hffff, 16'hffff, 0, 8'hff));  // rejected
    send(mk(REQ_PAN, 7, 255, 255, 0, 0, 0, 0));  // idle channel
    send(mk(REQ_PAN, 0, 64, 200, 0, 0, 0, 0));
    send(mk(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_QUERY, 7, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_STOP, 9, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_QUERY, 5, 0, 0, 0, 0, 0, 0));
    send(mk(3'd6, 31, 255, 255, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_STOP, 31, 0, 0, 0, 0, 0, 0));
    // full scale positive on several channels to hit saturation
    for (int c = 1; c <= 4; c++) send(mk(REQ_START, c, 255, 128, 16'hffff, 1, 100, 0));
    send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));
    send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));

    for (int n = 0; n < 520; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send(random_req());
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sound_effect_mixer.f
rtl/sfx_pkg.sv
rtl/sfx_if.sv
rtl/sfx_front.sv
rtl/sfx_back.sv
rtl/sound_effect_mixer.sv
tb/sfx_mix_checker.sv
tb/tb_top.sv
